>>> hdl/tmvg_pkg.sv
// Shared constants, types and a helper function of the torus mesh vertex generator.
// No dependencies; the files of the block that use it refer to it by scoped names.
package tmvg_pkg;

  localparam int MAX_RINGS    = 64;
  localparam int MAX_SEGMENTS = 32;

  // pipeline layout
  localparam int ANG_STG      = 34;
  localparam int CRD_STG      = 26;
  localparam int SHD_STG      = 4;
  localparam int CRD_BASE     = ANG_STG;
  localparam int SHD_BASE     = ANG_STG + CRD_STG;
  localparam int NSTG         = ANG_STG + CRD_STG + SHD_STG;
  localparam int DIV_STEPS    = 32;
  localparam int TEX_STEPS    = 17;
  localparam int CORDIC_STEPS = 24;

  localparam logic [14:0]        FULL_TURN    = 15'd23040;
  localparam logic signed [31:0] CORDIC_X0    = 32'sd652032874;
  localparam logic [31:0]        EIGHTH_TURN  = 32'h2000_0000;

  localparam logic signed [31:0] ATAN_TURN [0:CORDIC_STEPS-1] = '{
    32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85004756,
    32'sd42667331,  32'sd21354465,  32'sd10679838,  32'sd5340245,
    32'sd2670163,   32'sd1335087,   32'sd667544,    32'sd333772,
    32'sd166886,    32'sd83443,     32'sd41722,     32'sd20861,
    32'sd10430,     32'sd5215,      32'sd2608,      32'sd1304,
    32'sd652,       32'sd326,       32'sd163,       32'sd81
  };

  // register reset values
  localparam logic [14:0] RST_MAJOR_RADIUS = 15'd4096;
  localparam logic [14:0] RST_TUBE_RADIUS  = 15'd1638;
  localparam logic [6:0]  RST_RING_COUNT   = 7'd64;
  localparam logic [5:0]  RST_SEG_COUNT    = 6'd32;
  localparam logic [14:0] RST_START_ANGLE  = 15'd0;
  localparam logic [14:0] RST_SWEEP_ANGLE  = 15'd23040;

  typedef enum logic [2:0] {
    REG_MAJOR_RADIUS     = 3'd0,
    REG_TUBE_RADIUS      = 3'd1,
    REG_RING_COUNT       = 3'd2,
    REG_SEGMENT_COUNT    = 3'd3,
    REG_RING_START_ANGLE = 3'd4,
    REG_RING_SWEEP_ANGLE = 3'd5,
    REG_TUBE_START_ANGLE = 3'd6,
    REG_TUBE_SWEEP_ANGLE = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic signed [15:0] cosine;
    logic signed [15:0] sine;
  } trig_t;

  typedef struct packed {
    logic        quad_valid;
    logic [11:0] quad_base;
    logic        left_edge;
  } quad_t;

  typedef struct packed {
    logic [16:0] tex_u;
    logic [16:0] tex_v;
  } tex_t;

  // floor((v + 2^(sh-1)) / 2^sh), clamped to +-lim
  function automatic logic signed [39:0] round_sat(input logic signed [39:0] v,
                                                   input int unsigned sh,
                                                   input logic signed [39:0] lim);
    logic signed [39:0] r;
    r = (v + (40'sd1 <<< (sh - 1))) >>> sh;
    if (r > lim) begin
      r = lim;
    end else if (r < -lim) begin
      r = -lim;
    end
    return r;
  endfunction

endpackage

>>> hdl/tmvg_in_if.sv
// Input channel of the torus mesh vertex generator: one grid point per item.
// No dependencies.
interface tmvg_in_if;
  logic       valid;
  logic       ready;
  logic [6:0] ring_index;
  logic [5:0] segment_index;

  modport source (output valid, output ring_index, output segment_index, input ready);
  modport sink   (input valid, input ring_index, input segment_index, output ready);
endinterface

>>> hdl/tmvg_out_if.sv
// Result channel of the torus mesh vertex generator: one vertex per item.
// No dependencies.
interface tmvg_out_if;
  logic               valid;
  logic               ready;
  logic signed [16:0] pos_x;
  logic signed [16:0] pos_y;
  logic signed [15:0] pos_z;
  logic signed [15:0] norm_x;
  logic signed [15:0] norm_y;
  logic signed [15:0] norm_z;
  logic [16:0]        tex_u;
  logic [16:0]        tex_v;
  logic               quad_valid;
  logic [11:0]        quad_base;
  logic               left_edge;

  modport source (output valid, output pos_x, output pos_y, output pos_z,
                  output norm_x, output norm_y, output norm_z, output tex_u,
                  output tex_v, output quad_valid, output quad_base,
                  output left_edge, input ready);
  modport sink   (input valid, input pos_x, input pos_y, input pos_z,
                  input norm_x, input norm_y, input norm_z, input tex_u,
                  input tex_v, input quad_valid, input quad_base,
                  input left_edge, output ready);
endinterface

>>> hdl/tmvg_angle.sv
// Angle and texture front end for one axis: sweep product, modulo reduction and
// a 32-step pipelined divider to a binary angle, plus a 17-step texture divider.
// Depends on tmvg_pkg.
module tmvg_angle (
  input  logic                          clk,
  input  logic [tmvg_pkg::ANG_STG-1:0]  en,
  input  logic [14:0]                   start,
  input  logic [14:0]                   sweep,
  input  logic [6:0]                    idx,
  input  logic [6:0]                    cnt,
  output logic [31:0]                   ang,
  output logic [16:0]                   tex
);

  logic [22:0] sum_r;
  logic [20:0] mod0_r;
  logic [6:0]  idx0_r;
  logic [6:0]  cnt0_r;

  logic [21:0] prod_a;
  logic [21:0] prod_b;
  logic [22:0] sum_nxt;
  logic [20:0] mod_nxt;
  logic [22:0] red;

  logic [20:0] arem_r [0:tmvg_pkg::DIV_STEPS-1];
  logic [20:0] amod_r [0:tmvg_pkg::DIV_STEPS-1];
  logic [31:0] aq_r   [0:tmvg_pkg::DIV_STEPS-1];
  logic [6:0]  trem_r [0:tmvg_pkg::TEX_STEPS-1];
  logic [6:0]  tcnt_r [0:tmvg_pkg::TEX_STEPS-1];
  logic [16:0] tq_r   [0:tmvg_pkg::DIV_STEPS-1];

  always_comb begin
    prod_a  = 22'(start) * 22'(cnt);
    prod_b  = 22'(idx) * 22'(sweep);
    sum_nxt = 23'(prod_a) + 23'(prod_b);
    mod_nxt = 21'(tmvg_pkg::FULL_TURN) * 21'(cnt);
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      sum_r  <= sum_nxt;
      mod0_r <= mod_nxt;
      idx0_r <= idx;
      cnt0_r <= cnt;
    end
  end

  // sum stays below three turns
  always_comb begin
    if (sum_r >= {1'b0, mod0_r, 1'b0}) begin
      red = sum_r - {1'b0, mod0_r, 1'b0};
    end else if (sum_r >= {2'b00, mod0_r}) begin
      red = sum_r - {2'b00, mod0_r};
    end else begin
      red = sum_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      arem_r[0] <= red[20:0];
      amod_r[0] <= mod0_r;
      trem_r[0] <= idx0_r;
      tcnt_r[0] <= cnt0_r;
    end
  end

  // angle divider: (num * 2^32 + mod / 2) / mod
  for (genvar K = 0; K < tmvg_pkg::DIV_STEPS; K++) begin : g_div
    logic [31:0] half;
    logic [21:0] ar2;
    logic [21:0] ard;
    logic        ge;
    assign half = 32'(amod_r[K] >> 1);
    assign ar2  = {arem_r[K], half[31-K]};
    assign ge   = ar2 >= {1'b0, amod_r[K]};
    assign ard  = ge ? ar2 - {1'b0, amod_r[K]} : ar2;
    if (K == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (en[K+2]) aq_r[K] <= {31'd0, ge};
      end
    end else begin : g_next
      always_ff @(posedge clk) begin
        if (en[K+2]) aq_r[K] <= {aq_r[K-1][30:0], ge};
      end
    end
    if (K < tmvg_pkg::DIV_STEPS - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en[K+2]) begin
          arem_r[K+1] <= ard[20:0];
          amod_r[K+1] <= amod_r[K];
        end
      end
    end
  end

  // texture divider: (idx * 2^17 + cnt) / (2 * cnt)
  for (genvar K = 0; K < tmvg_pkg::DIV_STEPS; K++) begin : g_tex
    if (K < tmvg_pkg::TEX_STEPS) begin : g_step
      logic [16:0] tlow;
      logic [7:0]  tr2;
      logic [7:0]  tdiv;
      logic [7:0]  trd;
      logic        tge;
      assign tlow = 17'(tcnt_r[K]);
      assign tr2  = {trem_r[K], tlow[16-K]};
      assign tdiv = {tcnt_r[K], 1'b0};
      assign tge  = tr2 >= tdiv;
      assign trd  = tge ? tr2 - tdiv : tr2;
      if (K == 0) begin : g_first
        always_ff @(posedge clk) begin
          if (en[K+2]) tq_r[K] <= {16'd0, tge};
        end
      end else begin : g_next
        always_ff @(posedge clk) begin
          if (en[K+2]) tq_r[K] <= {tq_r[K-1][15:0], tge};
        end
      end
      if (K < tmvg_pkg::TEX_STEPS - 1) begin : g_carry
        always_ff @(posedge clk) begin
          if (en[K+2]) begin
            trem_r[K+1] <= trd[6:0];
            tcnt_r[K+1] <= tcnt_r[K];
          end
        end
      end
    end else begin : g_hold
      always_ff @(posedge clk) begin
        if (en[K+2]) tq_r[K] <= tq_r[K-1];
      end
    end
  end

  assign ang = aq_r[tmvg_pkg::DIV_STEPS-1];
  assign tex = tq_r[tmvg_pkg::DIV_STEPS-1];

endmodule

>>> hdl/tmvg_cordic.sv
// Pipelined sine and cosine: quadrant fold, 24 rotation steps, and Q1.14 rounding with
// quadrant restore, one stage each. Depends on tmvg_pkg.
module tmvg_cordic (
  input  logic                          clk,
  input  logic [tmvg_pkg::CRD_STG-1:0]  en,
  input  logic [31:0]                   ang,
  output tmvg_pkg::trig_t               trig
);

  localparam int N = tmvg_pkg::CORDIC_STEPS;

  logic signed [31:0] x_r [0:N];
  logic signed [31:0] y_r [0:N];
  logic signed [31:0] z_r [0:N-1];
  logic [1:0]         quad_r [0:N];
  tmvg_pkg::trig_t    trig_r;

  logic [31:0]        t;
  logic signed [15:0] cs;
  logic signed [15:0] sn;
  tmvg_pkg::trig_t    trig_nxt;

  assign t = ang + tmvg_pkg::EIGHTH_TURN;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      quad_r[0] <= t[31:30];
      z_r[0]    <= $signed({2'b00, t[29:0]}) - $signed(tmvg_pkg::EIGHTH_TURN);
      x_r[0]    <= tmvg_pkg::CORDIC_X0;
      y_r[0]    <= 32'sd0;
    end
  end

  for (genvar K = 0; K < N; K++) begin : g_rot
    logic signed [31:0] dx;
    logic signed [31:0] dy;
    logic               pos;
    assign dx  = y_r[K] >>> K;
    assign dy  = x_r[K] >>> K;
    assign pos = ~z_r[K][31];
    always_ff @(posedge clk) begin
      if (en[K+1]) begin
        x_r[K+1]    <= pos ? x_r[K] - dx : x_r[K] + dx;
        y_r[K+1]    <= pos ? y_r[K] + dy : y_r[K] - dy;
        quad_r[K+1] <= quad_r[K];
      end
    end
    if (K < N - 1) begin : g_z
      always_ff @(posedge clk) begin
        if (en[K+1]) begin
          z_r[K+1] <= pos ? z_r[K] - tmvg_pkg::ATAN_TURN[K]
                          : z_r[K] + tmvg_pkg::ATAN_TURN[K];
        end
      end
    end
  end

  always_comb begin
    cs = 16'(tmvg_pkg::round_sat(40'(x_r[N]), 16, 40'sd16384));
    sn = 16'(tmvg_pkg::round_sat(40'(y_r[N]), 16, 40'sd16384));
    case (quad_r[N])
      2'd0: begin
        trig_nxt.cosine = cs;
        trig_nxt.sine   = sn;
      end
      2'd1: begin
        trig_nxt.cosine = -sn;
        trig_nxt.sine   = cs;
      end
      2'd2: begin
        trig_nxt.cosine = -cs;
        trig_nxt.sine   = -sn;
      end
      default: begin
        trig_nxt.cosine = sn;
        trig_nxt.sine   = -cs;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en[N+1]) trig_r <= trig_nxt;
  end

  assign trig = trig_r;

endmodule

>>> hdl/tmvg_shade.sv
// Vertex position and normal from the two sine/cosine pairs and the radii,
// four stages of Q1.14 products with rounding and saturation. Depends on tmvg_pkg.
module tmvg_shade (
  input  logic                          clk,
  input  logic [tmvg_pkg::SHD_STG-1:0]  en,
  input  tmvg_pkg::trig_t               trig_u,
  input  tmvg_pkg::trig_t               trig_v,
  input  logic [14:0]                   major,
  input  logic [14:0]                   tube,
  output logic signed [16:0]            pos_x,
  output logic signed [16:0]            pos_y,
  output logic signed [15:0]            pos_z,
  output logic signed [15:0]            norm_x,
  output logic signed [15:0]            norm_y,
  output logic signed [15:0]            norm_z
);

  logic signed [15:0] cu;
  logic signed [15:0] su;
  logic signed [15:0] cv;
  logic signed [15:0] sv;
  logic signed [15:0] tube_s;
  logic signed [31:0] prcv_nxt;
  logic signed [31:0] pnx_nxt;
  logic signed [31:0] pny_nxt;
  logic signed [31:0] pz_nxt;

  logic signed [31:0] prcv_r, pnx_r, pny_r, pz_r;
  logic signed [15:0] cu0_r, su0_r, sv0_r;

  logic signed [31:0] rcv;
  logic signed [31:0] ring_w;
  logic signed [17:0] ring_r;
  logic signed [15:0] cu1_r, su1_r, sv1_r, nx1_r, ny1_r, pz1_r;

  logic signed [33:0] ppx_nxt;
  logic signed [33:0] ppy_nxt;
  logic signed [33:0] ppx_r, ppy_r;
  logic signed [15:0] sv2_r, nx2_r, ny2_r, pz2_r;

  logic signed [16:0] pos_x_r, pos_y_r;
  logic signed [15:0] pos_z_r, norm_x_r, norm_y_r, norm_z_r;

  assign cu     = trig_u.cosine;
  assign su     = trig_u.sine;
  assign cv     = trig_v.cosine;
  assign sv     = trig_v.sine;
  assign tube_s = {1'b0, tube};

  always_comb begin
    prcv_nxt = tube_s * cv;
    pnx_nxt  = cv * cu;
    pny_nxt  = cv * su;
    pz_nxt   = tube_s * sv;
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      prcv_r <= prcv_nxt;
      pnx_r  <= pnx_nxt;
      pny_r  <= pny_nxt;
      pz_r   <= pz_nxt;
      cu0_r  <= cu;
      su0_r  <= su;
      sv0_r  <= sv;
    end
  end

  always_comb begin
    rcv    = (prcv_r + 32'sd8192) >>> 14;
    ring_w = $signed({17'd0, major}) + rcv;
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      ring_r <= ring_w[17:0];
      cu1_r  <= cu0_r;
      su1_r  <= su0_r;
      sv1_r  <= sv0_r;
      nx1_r  <= 16'(tmvg_pkg::round_sat(40'(pnx_r), 14, 40'sd16384));
      ny1_r  <= 16'(tmvg_pkg::round_sat(40'(pny_r), 14, 40'sd16384));
      pz1_r  <= 16'(tmvg_pkg::round_sat(40'(pz_r), 14, 40'sd32767));
    end
  end

  always_comb begin
    ppx_nxt = ring_r * cu1_r;
    ppy_nxt = ring_r * su1_r;
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      ppx_r <= ppx_nxt;
      ppy_r <= ppy_nxt;
      sv2_r <= sv1_r;
      nx2_r <= nx1_r;
      ny2_r <= ny1_r;
      pz2_r <= pz1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      pos_x_r  <= 17'(tmvg_pkg::round_sat(40'(ppx_r), 14, 40'sd65535));
      pos_y_r  <= 17'(tmvg_pkg::round_sat(40'(ppy_r), 14, 40'sd65535));
      pos_z_r  <= pz2_r;
      norm_x_r <= nx2_r;
      norm_y_r <= ny2_r;
      norm_z_r <= sv2_r;
    end
  end

  assign pos_x  = pos_x_r;
  assign pos_y  = pos_y_r;
  assign pos_z  = pos_z_r;
  assign norm_x = norm_x_r;
  assign norm_y = norm_y_r;
  assign norm_z = norm_z_r;

endmodule

>>> hdl/torus_mesh_vertex_generator_top.sv
// Top level of the torus mesh vertex generator: registers, index clamps, valid
// pipeline and side lines. Depends on tmvg_pkg, the channel interfaces,
// tmvg_angle, tmvg_cordic and tmvg_shade.
//
//   port     dir   handshake             content
//   in_ch    in    valid/ready           ring_index, segment_index
//   out_ch   out   valid/ready           position, normal, texture, quad
//   cfg_*    in    APB, pready always 1  eight registers at 4*i
//
// One item per cycle while out_ch is not stalled; the pipeline holds the 32-step angle
// divider and the 24-step CORDIC, each one step per stage.
// rst_n is synchronous: it empties the pipeline and loads register defaults.
// Each stage holds while the next is full and stalled; bubbles close up, so
// input is taken while a result waits as long as any stage is empty.
module torus_mesh_vertex_generator_top (
  input  logic              clk,
  input  logic              rst_n,
  tmvg_in_if.sink           in_ch,
  tmvg_out_if.source        out_ch,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [4:0]        cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);

  localparam int NSTG  = tmvg_pkg::NSTG;
  localparam int TEX_N = NSTG - tmvg_pkg::CRD_BASE;

  logic [14:0] major_r, tube_r;
  logic [6:0]  ring_count_r;
  logic [5:0]  seg_count_r;
  logic [14:0] ring_start_r, ring_sweep_r, tube_start_r, tube_sweep_r;

  logic [NSTG-1:0] vld_r, vld_nxt, en;

  logic [6:0]  rc, j;
  logic [5:0]  sc, i;
  logic [12:0] base_w;
  tmvg_pkg::quad_t quad_nxt;
  tmvg_pkg::quad_t quad_r [0:NSTG-1];
  tmvg_pkg::tex_t  tex_r  [0:TEX_N-1];

  logic [31:0] ang_u, ang_v;
  logic [16:0] tex_ring, tex_seg;
  tmvg_pkg::trig_t trig_u, trig_v;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      major_r      <= tmvg_pkg::RST_MAJOR_RADIUS;
      tube_r       <= tmvg_pkg::RST_TUBE_RADIUS;
      ring_count_r <= tmvg_pkg::RST_RING_COUNT;
      seg_count_r  <= tmvg_pkg::RST_SEG_COUNT;
      ring_start_r <= tmvg_pkg::RST_START_ANGLE;
      ring_sweep_r <= tmvg_pkg::RST_SWEEP_ANGLE;
      tube_start_r <= tmvg_pkg::RST_START_ANGLE;
      tube_sweep_r <= tmvg_pkg::RST_SWEEP_ANGLE;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      case (tmvg_pkg::reg_idx_t'(cfg_paddr[4:2]))
        tmvg_pkg::REG_MAJOR_RADIUS:     major_r      <= cfg_pwdata[14:0];
        tmvg_pkg::REG_TUBE_RADIUS:      tube_r       <= cfg_pwdata[14:0];
        tmvg_pkg::REG_RING_COUNT:       ring_count_r <= cfg_pwdata[6:0];
        tmvg_pkg::REG_SEGMENT_COUNT:    seg_count_r  <= cfg_pwdata[5:0];
        tmvg_pkg::REG_RING_START_ANGLE: ring_start_r <= cfg_pwdata[14:0];
        tmvg_pkg::REG_RING_SWEEP_ANGLE: ring_sweep_r <= cfg_pwdata[14:0];
        tmvg_pkg::REG_TUBE_START_ANGLE: tube_start_r <= cfg_pwdata[14:0];
        tmvg_pkg::REG_TUBE_SWEEP_ANGLE: tube_sweep_r <= cfg_pwdata[14:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (tmvg_pkg::reg_idx_t'(cfg_paddr[4:2]))
      tmvg_pkg::REG_MAJOR_RADIUS:     cfg_prdata = 32'(major_r);
      tmvg_pkg::REG_TUBE_RADIUS:      cfg_prdata = 32'(tube_r);
      tmvg_pkg::REG_RING_COUNT:       cfg_prdata = 32'(ring_count_r);
      tmvg_pkg::REG_SEGMENT_COUNT:    cfg_prdata = 32'(seg_count_r);
      tmvg_pkg::REG_RING_START_ANGLE: cfg_prdata = 32'(ring_start_r);
      tmvg_pkg::REG_RING_SWEEP_ANGLE: cfg_prdata = 32'(ring_sweep_r);
      tmvg_pkg::REG_TUBE_START_ANGLE: cfg_prdata = 32'(tube_start_r);
      tmvg_pkg::REG_TUBE_SWEEP_ANGLE: cfg_prdata = 32'(tube_sweep_r);
      default:                        cfg_prdata = 32'd0;
    endcase
  end

  assign cfg_pready = 1'b1;

  // count and index clamps, quad corner
  always_comb begin
    if (ring_count_r == 7'd0) begin
      rc = 7'd1;
    end else if (ring_count_r > 7'(tmvg_pkg::MAX_RINGS)) begin
      rc = 7'(tmvg_pkg::MAX_RINGS);
    end else begin
      rc = ring_count_r;
    end
    if (seg_count_r == 6'd0) begin
      sc = 6'd1;
    end else if (seg_count_r > 6'(tmvg_pkg::MAX_SEGMENTS)) begin
      sc = 6'(tmvg_pkg::MAX_SEGMENTS);
    end else begin
      sc = seg_count_r;
    end
    j = (in_ch.ring_index > rc) ? rc : in_ch.ring_index;
    i = (in_ch.segment_index > sc) ? sc : in_ch.segment_index;
    base_w = 13'({1'b0, sc} + 7'd1) * 13'(j - 7'd1) + 13'(i - 6'd1);
    quad_nxt.quad_valid = (i != 6'd0) && (j != 7'd0);
    if (!quad_nxt.quad_valid) begin
      quad_nxt.quad_base = 12'd0;
    end else if (base_w > 13'd4095) begin
      quad_nxt.quad_base = 12'd4095;
    end else begin
      quad_nxt.quad_base = base_w[11:0];
    end
    quad_nxt.left_edge = quad_nxt.quad_valid && (i == 6'd1);
  end

  // stage enables: a stage moves when out_ch is ready or any stage from it onward is empty
  for (genvar K = 0; K < NSTG; K++) begin : g_en
    assign en[K] = out_ch.ready | ~(&vld_r[NSTG-1:K]);
  end

  always_comb begin
    for (int k = 0; k < NSTG; k++) begin
      if (en[k]) begin
        vld_nxt[k] = (k == 0) ? in_ch.valid : vld_r[(k == 0) ? 0 : k - 1];
      end else begin
        vld_nxt[k] = vld_r[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_ch.ready  = en[0];
  assign out_ch.valid = vld_r[NSTG-1];

  // side lines
  always_ff @(posedge clk) begin
    if (en[0]) quad_r[0] <= quad_nxt;
  end

  for (genvar K = 1; K < NSTG; K++) begin : g_quad
    always_ff @(posedge clk) begin
      if (en[K]) quad_r[K] <= quad_r[K-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en[tmvg_pkg::CRD_BASE]) begin
      tex_r[0].tex_u <= tex_seg;
      tex_r[0].tex_v <= tex_ring;
    end
  end

  for (genvar K = 1; K < TEX_N; K++) begin : g_tex
    always_ff @(posedge clk) begin
      if (en[tmvg_pkg::CRD_BASE + K]) tex_r[K] <= tex_r[K-1];
    end
  end

  tmvg_angle u_angle_ring (
    .clk   (clk),
    .en    (en[tmvg_pkg::ANG_STG-1:0]),
    .start (ring_start_r),
    .sweep (ring_sweep_r),
    .idx   (j),
    .cnt   (rc),
    .ang   (ang_u),
    .tex   (tex_ring)
  );

  tmvg_angle u_angle_tube (
    .clk   (clk),
    .en    (en[tmvg_pkg::ANG_STG-1:0]),
    .start (tube_start_r),
    .sweep (tube_sweep_r),
    .idx   ({1'b0, i}),
    .cnt   ({1'b0, sc}),
    .ang   (ang_v),
    .tex   (tex_seg)
  );

  tmvg_cordic u_cordic_ring (
    .clk  (clk),
    .en   (en[tmvg_pkg::CRD_BASE +: tmvg_pkg::CRD_STG]),
    .ang  (ang_u),
    .trig (trig_u)
  );

  tmvg_cordic u_cordic_tube (
    .clk  (clk),
    .en   (en[tmvg_pkg::CRD_BASE +: tmvg_pkg::CRD_STG]),
    .ang  (ang_v),
    .trig (trig_v)
  );

  tmvg_shade u_shade (
    .clk    (clk),
    .en     (en[tmvg_pkg::SHD_BASE +: tmvg_pkg::SHD_STG]),
    .trig_u (trig_u),
    .trig_v (trig_v),
    .major  (major_r),
    .tube   (tube_r),
    .pos_x  (out_ch.pos_x),
    .pos_y  (out_ch.pos_y),
    .pos_z  (out_ch.pos_z),
    .norm_x (out_ch.norm_x),
    .norm_y (out_ch.norm_y),
    .norm_z (out_ch.norm_z)
  );

  assign out_ch.tex_u      = tex_r[TEX_N-1].tex_u;
  assign out_ch.tex_v      = tex_r[TEX_N-1].tex_v;
  assign out_ch.quad_valid = quad_r[NSTG-1].quad_valid;
  assign out_ch.quad_base  = quad_r[NSTG-1].quad_base;
  assign out_ch.left_edge  = quad_r[NSTG-1].left_edge;

endmodule

>>> hdl/tmvg_checker.sv
// Port-level checks of the torus mesh vertex generator and the bind that
// attaches them to torus_mesh_vertex_generator_top.
module tmvg_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [16:0] out_pos_x,
  input logic signed [15:0] out_norm_x,
  input logic [16:0]        out_tex_u,
  input logic               out_quad_valid,
  input logic [11:0]        out_quad_base,
  input logic               out_left_edge
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_pos_x) && $stable(out_quad_base))
    else $error("stalled item changed or dropped");

  a_no_quad: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_quad_valid |-> out_quad_base == 12'd0 && !out_left_edge)
    else $error("quad fields set without a quad");

  a_left_edge: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_left_edge |-> out_quad_valid)
    else $error("left edge without a quad");

  a_ranges: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_norm_x <= 16'sd16384 && out_norm_x >= -16'sd16384 &&
                  out_tex_u <= 17'd65536)
    else $error("normal or texture out of range");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("pipeline not empty after reset");

endmodule

bind torus_mesh_vertex_generator_top tmvg_checker u_tmvg_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_pos_x      (out_ch.pos_x),
  .out_norm_x     (out_ch.norm_x),
  .out_tex_u      (out_ch.tex_u),
  .out_quad_valid (out_ch.quad_valid),
  .out_quad_base  (out_ch.quad_base),
  .out_left_edge  (out_ch.left_edge)
);
